// ===== design/bf3m_pkg.sv =====
// Shared types and constants for the 3x3 box mean filter.
package bf3m_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int MEAN_W     = 24;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEAN_W-1:0]   mean_t;
  typedef logic [ROW_W-1:0]           row_t;
  typedef logic [COL_W-1:0]           col_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [FH_W-1:0] HEIGHT_RESET = 16'd1024;

  // (2^33 + 1) / 9: exact floor divide by 9 for dividends below 2^33
  localparam logic [29:0] RECIP9      = 30'd954437177;
  // window sum offset 9 * 32768 keeps the dividend non-negative
  localparam logic signed [20:0] SUM_OFFSET = 21'sd294912;

endpackage

// ===== design/bf3m_if.sv =====
// Channel interfaces: pixel input, filtered result output, register writes.
interface bf3m_pix_if;
  logic              valid;
  logic              ready;
  bf3m_pkg::sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bf3m_res_if;
  logic             valid;
  logic             ready;
  bf3m_pkg::mean_t  mean_value;
  bf3m_pkg::row_t   out_row;
  bf3m_pkg::col_t   out_col;
  logic             last_of_run;
  modport source (output valid, output mean_value, output out_row, output out_col,
                  output last_of_run, input ready);
  modport sink   (input valid, input mean_value, input out_row, input out_col,
                  input last_of_run, output ready);
endinterface

interface bf3m_cfg_if;
  logic                valid;
  logic                ready;
  bf3m_pkg::cfg_idx_t  index;
  bf3m_pkg::cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/box_filter_3x3_mean.sv =====
// Streaming 3x3 box mean filter with two line stores and a result serialiser.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-----------
//  cfg      | in  | index, data (0: frame_width, 1: height)   | valid/ready
//  pixel    | in  | sample                                    | valid/ready
//  result   | out | mean_value, out_row, out_col, last_of_run | valid/ready
//
// One pixel per cycle while the result channel is ready. A pixel that raises two
// or three results holds the input while the serialiser drains it.
// The first result of a pixel is offered after the input, window, sum and multiply stages.
// Synchronous reset clears control, position and window; the line stores
// are not cleared. The whole pipeline stalls together on result back-pressure.
module box_filter_3x3_mean (
  input  logic      clk,
  input  logic      rst,
  bf3m_cfg_if.sink  cfg,
  bf3m_pix_if.sink  pixel,
  bf3m_res_if.source result
);
  import bf3m_pkg::*;

  typedef struct packed {
    logic    e0;
    logic    e1;
    logic    e2;
    logic    inter;
    sample_t b0;
    sample_t v1;
    sample_t v2;
    row_t    row;
    col_t    col;
  } item_t;

  // configuration
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = FW_W'(1);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  // handshake and pipeline advance
  logic adv;
  logic accept;
  logic [2:0] mask;
  logic take;
  logic single;

  assign single = ((mask & (mask - 3'd1)) == 3'd0);
  assign take   = result.valid && result.ready;
  assign adv    = (mask == 3'd0) || (take && single);
  assign accept = pixel.valid && adv;
  assign pixel.ready = adv;

  // position
  row_t row_pos;
  col_t col_pos;
  logic col_wrap;
  logic row_wrap;

  assign col_wrap = ({1'b0, col_pos} + FW_W'(1)) >= w_eff;
  assign row_wrap = ({1'b0, row_pos} + 17'd1) >= {1'b0, h_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_pos <= '0;
        row_pos <= row_wrap ? '0 : row_pos + row_t'(1);
      end else begin
        col_pos <= col_pos + col_t'(1);
      end
    end
  end

  // input stage and line stores
  logic    p1_valid;
  sample_t p1_sample;
  row_t    p1_row;
  col_t    p1_col;
  sample_t older_mem [MAX_WIDTH];
  sample_t newer_mem [MAX_WIDTH];
  sample_t older_rd;
  sample_t newer_rd;
  logic    fwd;
  sample_t fwd_older;
  sample_t fwd_newer;
  sample_t older_eff;
  sample_t newer_eff;

  assign older_eff = fwd ? fwd_older : older_rd;
  assign newer_eff = fwd ? fwd_newer : newer_rd;

  always_ff @(posedge clk) begin
    if (accept) begin
      older_rd <= older_mem[col_pos];
      newer_rd <= newer_mem[col_pos];
    end
    if (p1_valid) begin
      older_mem[p1_col] <= newer_eff;
      newer_mem[p1_col] <= p1_sample;
    end
  end

  // bypass when the stage ahead writes the column being read (one-pixel rows)
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (accept) begin
      fwd <= p1_valid && (p1_col == col_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_older <= newer_eff;
      fwd_newer <= p1_sample;
      p1_sample <= pixel.sample;
      p1_row    <= row_pos;
      p1_col    <= col_pos;
    end
  end

  // result decisions for the pixel in the input stage
  item_t p1_item;
  logic signed [17:0] colsum_new;
  sample_t nprev;

  always_comb begin
    p1_item.e0    = (p1_row != '0) && (p1_col != '0);
    p1_item.inter = (p1_row >= row_t'(2)) && (p1_row < h_eff) &&
                    (p1_col >= col_t'(2)) && ({1'b0, p1_col} < w_eff);
    p1_item.e1    = (p1_row != '0) && (({1'b0, p1_col} + FW_W'(1)) == w_eff);
    p1_item.e2    = ({1'b0, p1_row} + 17'd1) == {1'b0, h_eff};
    p1_item.b0    = nprev;
    p1_item.v1    = newer_eff;
    p1_item.v2    = p1_sample;
    p1_item.row   = p1_row;
    p1_item.col   = p1_col;
  end

  assign colsum_new = 18'(older_eff) + 18'(newer_eff) + 18'(p1_sample);

  // window stage: column sums of the 3x3 window
  logic               p2_valid;
  item_t              p2_item;
  logic signed [17:0] cs0;
  logic signed [17:0] cs1;
  logic signed [17:0] cs2;
  logic signed [20:0] win_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      cs0   <= '0;
      cs1   <= '0;
      cs2   <= '0;
      nprev <= '0;
    end else if (adv && p1_valid) begin
      cs0   <= cs1;
      cs1   <= cs2;
      cs2   <= colsum_new;
      nprev <= newer_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_item <= p1_item;
    end
  end

  assign win_sum = 21'(cs0) + 21'(cs1) + 21'(cs2) + SUM_OFFSET;

  // sum stage
  logic        p3_valid;
  item_t       p3_item;
  logic [19:0] p3_u;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_item <= p2_item;
      p3_u    <= 20'(win_sum);
    end
  end

  // multiply stage
  logic        p4_valid;
  item_t       p4_item;
  logic [49:0] p4_prod;
  logic [23:0] quot;
  mean_t       mean_res;

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_item <= p3_item;
      p4_prod <= 50'(p3_u) * 50'(RECIP9);
    end
  end

  // floor(u*256/9) less the offset, i.e. the top bit flipped
  assign quot     = p4_prod[48:25];
  assign mean_res = {~quot[23], quot[22:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= pixel.valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  // result serialiser: up to three results per item
  mean_t     res_val [3];
  row_t      res_row [3];
  col_t      res_col [3];
  logic [1:0] sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (adv) begin
      mask <= {p4_item.e2, p4_item.e1, p4_item.e0} & {3{p4_valid}};
    end else if (take) begin
      mask <= mask & (mask - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_val[0] <= p4_item.inter ? mean_res : {p4_item.b0, 8'h00};
      res_row[0] <= p4_item.row - row_t'(1);
      res_col[0] <= p4_item.col - col_t'(1);
      res_val[1] <= {p4_item.v1, 8'h00};
      res_row[1] <= p4_item.row - row_t'(1);
      res_col[1] <= p4_item.col;
      res_val[2] <= {p4_item.v2, 8'h00};
      res_row[2] <= p4_item.row;
      res_col[2] <= p4_item.col;
    end
  end

  always_comb begin
    if (mask[0]) begin
      sel = 2'd0;
    end else if (mask[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign result.valid       = (mask != 3'd0);
  assign result.mean_value  = res_val[sel];
  assign result.out_row     = res_row[sel];
  assign result.out_col     = res_col[sel];
  assign result.last_of_run = single;

endmodule

// ===== tb/box_filter_3x3_mean_tb.sv =====
// Self-checking testbench for the 3x3 box mean filter: random frames against a predictor.
module box_filter_3x3_mean_tb;
  import bf3m_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 200;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  typedef struct {
    mean_t value;
    row_t  row;
    col_t  col;
    logic  last_flag;
  } filtered_px_t;

  class mean_scoreboard;
    logic [FW_W-1:0] frame_width;
    logic [FH_W-1:0] frame_height;
    sample_t         older_line[MAX_WIDTH];
    sample_t         newer_line[MAX_WIDTH];
    sample_t         win[3][3];
    row_t            row_pos;
    col_t            col_pos;
    filtered_px_t    expected_means[$];
    int              mismatches;

    function new();
      frame_width  = WIDTH_RESET;
      frame_height = HEIGHT_RESET;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      foreach (win[i, k]) win[i][k] = '0;
      row_pos    = '0;
      col_pos    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_FRAME_WIDTH:  frame_width  = data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height = data[FH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (frame_width == 0) return 1;
      if (frame_width > MAX_WIDTH) return MAX_WIDTH;
      return frame_width;
    endfunction

    function int unsigned eff_height();
      return (frame_height == 0) ? 1 : frame_height;
    endfunction

    function int unsigned frame_pixels();
      return eff_width() * eff_height();
    endfunction

    function int pending();
      return expected_means.size();
    endfunction

    function void note_pixel(sample_t s);
      int unsigned  w, h, r, c;
      int           sum, scaled, q, n;
      filtered_px_t found[3];
      w = eff_width();
      h = eff_height();
      r = row_pos;
      c = col_pos;
      n = 0;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = older_line[c];
      win[1][2] = newer_line[c];
      win[2][2] = s;

      if (r >= 1 && c >= 1) begin
        if (r >= 2 && r < h && c >= 2 && c < w) begin
          sum = 0;
          foreach (win[i, k]) sum += int'(win[i][k]);
          scaled = sum * 256;
          q = scaled / 9;
          if (scaled < 0 && scaled % 9 != 0) q--;
          found[n].value = mean_t'(q);
        end else begin
          found[n].value = mean_t'(int'(win[1][1]) * 256);
        end
        found[n].row = row_t'(r - 1);
        found[n].col = col_t'(c - 1);
        n++;
      end
      if (r >= 1 && c + 1 == w) begin
        found[n].value = mean_t'(int'(win[1][2]) * 256);
        found[n].row   = row_t'(r - 1);
        found[n].col   = col_t'(c);
        n++;
      end
      if (r + 1 == h) begin
        found[n].value = mean_t'(int'(s) * 256);
        found[n].row   = row_t'(r);
        found[n].col   = col_t'(c);
        n++;
      end
      for (int k = 0; k < n; k++) begin
        found[k].last_flag = (k == n - 1);
        expected_means.push_back(found[k]);
      end

      older_line[c] = newer_line[c];
      newer_line[c] = s;
      if (c + 1 >= w) begin
        col_pos = '0;
        row_pos = (r + 1 >= h) ? '0 : row_t'(r + 1);
      end else begin
        col_pos = col_t'(c + 1);
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", what);
    endtask

    task check_mean(mean_t m, row_t r, col_t c, logic last_flag);
      filtered_px_t want;
      if (expected_means.size() == 0) begin
        report($sformatf("result with nothing pending: row %0d col %0d mean %0d", r, c, m));
        return;
      end
      want = expected_means.pop_front();
      if (m !== want.value)
        report($sformatf("mean at (%0d,%0d): got %0d, want %0d",
                         want.row, want.col, m, want.value));
      if (r !== want.row)
        report($sformatf("row: got %0d, want %0d", r, want.row));
      if (c !== want.col)
        report($sformatf("col at row %0d: got %0d, want %0d", want.row, c, want.col));
      if (last_flag !== want.last_flag)
        report($sformatf("last_of_run at (%0d,%0d): got %b, want %b",
                         want.row, want.col, last_flag, want.last_flag));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   tx_idle = 1'b1;
  bit   rx_idle = 1'b1;
  bit   stall_hold = 1'b0;
  int   pixels_taken = 0;

  bf3m_cfg_if cfg();
  bf3m_pix_if pixel();
  bf3m_res_if result();

  mean_scoreboard mean_board = new();

  box_filter_3x3_mean DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pixel  (pixel),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_pixel(sample_t s);
    int idle_cycles;
    if ($urandom_range(0, 63) == 0) tx_idle = ($urandom_range(0, 3) != 0);
    idle_cycles = tx_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (idle_cycles > 0) begin
      pixel.valid <= 1'b0;
      repeat (idle_cycles) @(negedge clk);
    end
    pixel.valid  <= 1'b1;
    pixel.sample <= s;
    do @(posedge clk); while (!pixel.ready);
    mean_board.note_pixel(s);
    pixels_taken++;
  endtask

  task automatic send_frame();
    int unsigned count;
    count = mean_board.frame_pixels();
    repeat (count) send_pixel(rand_sample());
  endtask

  task automatic flush_and_settle();
    @(negedge clk);
    pixel.valid <= 1'b0;
    while (mean_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    mean_board.write_reg(idx, data);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_frame(cfg_data_t width_word, cfg_data_t height_word);
    flush_and_settle();
    write_reg(REG_FRAME_WIDTH, width_word);
    write_reg(REG_FRAME_HEIGHT, height_word);
  endtask

  initial begin : stimulus
    int        small_pixels;
    cfg_data_t width_word;
    small_pixels = 0;
    rst          = 1'b1;
    cfg.valid    = 1'b0;
    cfg.index    = '0;
    cfg.data     = '0;
    pixel.valid  = 1'b0;
    pixel.sample = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full-scale interior, then a negative sum that is not a multiple of nine
    set_frame(cfg_data_t'(3), cfg_data_t'(3));
    repeat (9) send_pixel(SAMPLE_MAX);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? sample_t'(-1) : SAMPLE_MIN);

    // zero width and height behave as one
    set_frame(cfg_data_t'(0), cfg_data_t'(0));
    send_pixel('0);
    send_pixel(SAMPLE_MAX);
    send_pixel(SAMPLE_MIN);

    // tallest frame, then shrink the height while past its last row
    set_frame(cfg_data_t'(16'hF801), cfg_data_t'(16'hFFFF));
    repeat (4) send_pixel(rand_sample());
    flush_and_settle();
    write_reg(REG_FRAME_HEIGHT, cfg_data_t'(2));
    send_pixel(rand_sample());

    while (small_pixels < 250) begin
      if ($urandom_range(0, 2) != 0) begin
        width_word = cfg_data_t'($urandom);
        width_word[FW_W-1:0] = ($urandom_range(0, 15) == 0) ? '0
                                                            : FW_W'($urandom_range(1, 12));
        set_frame(width_word, cfg_data_t'($urandom_range(0, 7)));
      end
      small_pixels += mean_board.frame_pixels();
      send_frame();
    end

    flush_and_settle();
    if (mean_board.mismatches == 0 && mean_board.pending() == 0) begin
      $display("[box_filter_3x3_mean] OK");
    end else begin
      $display("[box_filter_3x3_mean] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int idle_cycles;
    result.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_idle = ($urandom_range(0, 3) != 0);
      idle_cycles = rx_idle ? $urandom_range(0, 11) : 0;
      if (idle_cycles > 0 || stall_hold) begin
        result.ready <= 1'b0;
        repeat (idle_cycles) @(negedge clk);
        while (stall_hold) @(negedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      mean_board.check_mean(result.mean_value, result.out_row, result.out_col,
                            result.last_of_run);
      @(negedge clk);
    end
  end

  // long output stall after 120 pixels so the pipeline backs up onto the pixel input
  initial begin : result_hold
    wait (pixels_taken >= 120);
    @(posedge clk);
    stall_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_hold = 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pixel.valid && pixel.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[box_filter_3x3_mean] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bf3m_pkg.sv
design/bf3m_if.sv
design/box_filter_3x3_mean.sv
tb/box_filter_3x3_mean_tb.sv
